// File: rtl/lcdnib_pkg.sv
// Shared types, codes and the power-on init step table for the LCD nibble bus sequencer.
package lcdnib_pkg;

  localparam int unsigned HOLD_W        = 21;
  localparam int unsigned IDX_W         = 5;
  localparam logic [4:0]  INIT_LAST_IDX = 5'd24;
  localparam logic [1:0]  BYTE_LAST_SUB = 2'd3;
  localparam logic [7:0]  ROW0_BASE     = 8'h80;
  localparam logic [7:0]  ROW1_BASE     = 8'hC0;
  localparam logic [7:0]  CLEAR_CMD     = 8'h01;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 20;

  typedef enum logic [2:0] {
    ACT_CMD    = 3'd0,
    ACT_DATA   = 3'd1,
    ACT_CURSOR = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_INIT   = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    REG_ENABLE_PULSE = 3'd0,
    REG_NIBBLE_HOLD  = 3'd1,
    REG_CLEAR_WAIT   = 3'd2,
    REG_POWER_WAIT   = 3'd3,
    REG_LONG_WAIT    = 3'd4,
    REG_SHORT_WAIT   = 3'd5
  } cfg_reg_t;

  // Which timing register a step holds for.
  typedef enum logic [2:0] {
    HS_PULSE,
    HS_NIB,
    HS_NIB_CLR,
    HS_PWR,
    HS_LONG,
    HS_SHORT
  } hold_sel_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] byte_value;
    logic       cursor_row;
    logic [5:0] cursor_col;
  } in_item_t;

  typedef struct packed {
    logic              reg_select;
    logic [3:0]        bus_nibble;
    logic              enable_level;
    logic [HOLD_W-1:0] hold_us;
    logic              last_step;
  } out_item_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic       is_init;
    logic       reg_select;
    logic       add_clear;
    logic [7:0] byte_val;
  } job_t;

  typedef struct packed {
    logic [7:0]  enable_pulse_us;
    logic [15:0] nibble_hold_us;
    logic [15:0] clear_wait_us;
    logic [19:0] power_on_wait_us;
    logic [15:0] init_long_wait_us;
    logic [15:0] init_short_wait_us;
  } lcd_cfg_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] count;
  } queue_status_t;

  typedef struct packed {
    logic [3:0] nib;
    logic       en;
    hold_sel_t  hsel;
  } init_step_t;

  function automatic init_step_t init_step(input logic [IDX_W-1:0] idx);
    init_step_t s;
    s = '{nib: 4'h0, en: 1'b0, hsel: HS_PWR};
    case (idx)
      5'd0:  s = '{nib: 4'h0, en: 1'b0, hsel: HS_PWR};
      5'd1:  s = '{nib: 4'h3, en: 1'b1, hsel: HS_PULSE};
      5'd2:  s = '{nib: 4'h3, en: 1'b0, hsel: HS_LONG};
      5'd3:  s = '{nib: 4'h3, en: 1'b1, hsel: HS_PULSE};
      5'd4:  s = '{nib: 4'h3, en: 1'b0, hsel: HS_LONG};
      5'd5:  s = '{nib: 4'h3, en: 1'b1, hsel: HS_PULSE};
      5'd6:  s = '{nib: 4'h3, en: 1'b0, hsel: HS_SHORT};
      5'd7:  s = '{nib: 4'h2, en: 1'b1, hsel: HS_PULSE};
      5'd8:  s = '{nib: 4'h2, en: 1'b0, hsel: HS_SHORT};
      5'd9:  s = '{nib: 4'h2, en: 1'b1, hsel: HS_PULSE};
      5'd10: s = '{nib: 4'h2, en: 1'b0, hsel: HS_NIB};
      5'd11: s = '{nib: 4'h8, en: 1'b1, hsel: HS_PULSE};
      5'd12: s = '{nib: 4'h8, en: 1'b0, hsel: HS_NIB};
      5'd13: s = '{nib: 4'h0, en: 1'b1, hsel: HS_PULSE};
      5'd14: s = '{nib: 4'h0, en: 1'b0, hsel: HS_NIB};
      5'd15: s = '{nib: 4'hC, en: 1'b1, hsel: HS_PULSE};
      5'd16: s = '{nib: 4'hC, en: 1'b0, hsel: HS_NIB};
      5'd17: s = '{nib: 4'h0, en: 1'b1, hsel: HS_PULSE};
      5'd18: s = '{nib: 4'h0, en: 1'b0, hsel: HS_NIB};
      5'd19: s = '{nib: 4'h6, en: 1'b1, hsel: HS_PULSE};
      5'd20: s = '{nib: 4'h6, en: 1'b0, hsel: HS_NIB};
      5'd21: s = '{nib: 4'h0, en: 1'b1, hsel: HS_PULSE};
      5'd22: s = '{nib: 4'h0, en: 1'b0, hsel: HS_NIB};
      5'd23: s = '{nib: 4'h1, en: 1'b1, hsel: HS_PULSE};
      5'd24: s = '{nib: 4'h1, en: 1'b0, hsel: HS_NIB_CLR};
      default: s = '{nib: 4'h0, en: 1'b0, hsel: HS_PWR};
    endcase
    return s;
  endfunction

endpackage

// File: rtl/lcdnib_front.sv
// Front end: accept request beats and classify them into jobs for the queue.
module lcdnib_front (
  input  logic                     in_valid,
  output logic                     in_ready,
  input  lcdnib_pkg::in_item_t     in_data,
  input  lcdnib_pkg::queue_status_t q_status,
  output logic                     push,
  output lcdnib_pkg::job_t         push_job
);

  logic       known;
  logic [7:0] row_base;

  assign in_ready = !q_status.full;
  assign row_base = in_data.cursor_row ? lcdnib_pkg::ROW1_BASE : lcdnib_pkg::ROW0_BASE;

  always_comb begin
    known    = 1'b1;
    push_job = '{is_init: 1'b0, reg_select: 1'b0, add_clear: 1'b0,
                 byte_val: in_data.byte_value};
    case (lcdnib_pkg::action_t'(in_data.action))
      lcdnib_pkg::ACT_CMD: begin
      end
      lcdnib_pkg::ACT_DATA: begin
        push_job.reg_select = 1'b1;
      end
      lcdnib_pkg::ACT_CURSOR: begin
        push_job.byte_val = row_base + {2'b00, in_data.cursor_col};
      end
      lcdnib_pkg::ACT_CLEAR: begin
        push_job.byte_val  = lcdnib_pkg::CLEAR_CMD;
        push_job.add_clear = 1'b1;
      end
      lcdnib_pkg::ACT_INIT: begin
        push_job.is_init = 1'b1;
      end
      default: begin
        // drop unknown actions: accepted, no job
        known = 1'b0;
      end
    endcase
  end

  assign push = in_valid && in_ready && known;

endmodule

// File: rtl/lcdnib_queue.sv
// Two-entry job queue between the front and the back.
module lcdnib_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  lcdnib_pkg::job_t          push_job,
  input  logic                      pop,
  output lcdnib_pkg::job_t          head_job,
  output lcdnib_pkg::queue_status_t status
);

  lcdnib_pkg::job_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  assign head_job     = mem_r[rd_ptr_r];
  assign status.full  = count_r == 2'd2;
  assign status.empty = count_r == 2'd0;
  assign status.count = count_r;

endmodule

// File: rtl/lcdnib_back.sv
// Back end: walk each job through its pin steps into the output register.
module lcdnib_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lcdnib_pkg::lcd_cfg_t      cfg,
  input  lcdnib_pkg::queue_status_t q_status,
  input  lcdnib_pkg::job_t          head_job,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lcdnib_pkg::out_item_t     out_data
);

  lcdnib_pkg::back_state_t state_r, state_nxt;
  lcdnib_pkg::job_t        job_r;
  logic [lcdnib_pkg::IDX_W-1:0] idx_r;
  logic                    out_valid_r;
  lcdnib_pkg::out_item_t   out_data_r;

  lcdnib_pkg::init_step_t  ist;
  lcdnib_pkg::hold_sel_t   hsel;
  lcdnib_pkg::out_item_t   step;
  logic [1:0]              sub;
  logic                    load;
  logic                    fin;

  assign sub = idx_r[1:0];
  assign ist = lcdnib_pkg::init_step(idx_r);

  always_comb begin
    if (job_r.is_init) begin
      step.bus_nibble   = ist.nib;
      step.enable_level = ist.en;
      hsel              = ist.hsel;
      step.last_step    = idx_r == lcdnib_pkg::INIT_LAST_IDX;
      step.reg_select   = 1'b0;
    end else begin
      step.bus_nibble   = sub[1] ? job_r.byte_val[3:0] : job_r.byte_val[7:4];
      step.enable_level = !sub[0];
      step.last_step    = sub == lcdnib_pkg::BYTE_LAST_SUB;
      step.reg_select   = job_r.reg_select;
      if (!sub[0]) begin
        hsel = lcdnib_pkg::HS_PULSE;
      end else if (step.last_step && job_r.add_clear) begin
        hsel = lcdnib_pkg::HS_NIB_CLR;
      end else begin
        hsel = lcdnib_pkg::HS_NIB;
      end
    end
    case (hsel)
      lcdnib_pkg::HS_PULSE:   step.hold_us = 21'(cfg.enable_pulse_us);
      lcdnib_pkg::HS_NIB:     step.hold_us = 21'(cfg.nibble_hold_us);
      lcdnib_pkg::HS_NIB_CLR: step.hold_us = 21'(cfg.nibble_hold_us) + 21'(cfg.clear_wait_us);
      lcdnib_pkg::HS_PWR:     step.hold_us = 21'(cfg.power_on_wait_us);
      lcdnib_pkg::HS_LONG:    step.hold_us = 21'(cfg.init_long_wait_us);
      lcdnib_pkg::HS_SHORT:   step.hold_us = 21'(cfg.init_short_wait_us);
      default:                step.hold_us = '0;
    endcase
  end

  // Advance when the output slot is free or is being emptied this cycle.
  always_comb begin
    load      = !out_valid_r || out_ready;
    fin       = (state_r == lcdnib_pkg::BK_RUN) && load && step.last_step;
    pop       = !q_status.empty && ((state_r == lcdnib_pkg::BK_IDLE) || fin);
    state_nxt = state_r;
    case (state_r)
      lcdnib_pkg::BK_IDLE: if (pop) state_nxt = lcdnib_pkg::BK_RUN;
      lcdnib_pkg::BK_RUN:  if (fin && !pop) state_nxt = lcdnib_pkg::BK_IDLE;
      default:             state_nxt = lcdnib_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcdnib_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == lcdnib_pkg::BK_RUN) && load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= head_job;
      idx_r <= '0;
    end else if ((state_r == lcdnib_pkg::BK_RUN) && load) begin
      idx_r <= idx_r + 1'b1;
    end
    if ((state_r == lcdnib_pkg::BK_RUN) && load) begin
      out_data_r <= step;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/char_lcd_nibble_bus_sequencer_top.sv
// Top level of the character LCD 4-bit bus sequencer: config registers, front, queue, back.
//
//   channel | ports                         | beat
//   --------+-------------------------------+----------------------------------
//   request | in_valid, in_ready, in_data   | one action with byte / cursor
//   step    | out_valid, out_ready, out_data| one timed pin step
//   config  | cfg_we, cfg_index, cfg_wdata  | one timing register write
//
// A command, data, cursor or clear request yields four steps; init yields 25
// steps. The step output register sets the pace: one step leaves it per cycle
// while out_ready is high. Unknown actions are accepted and dropped. A two-entry
// queue lets requests land while the back end is busy; in_ready falls only when
// it is full. Reset is synchronous, active low, and loads the timing defaults.
module char_lcd_nibble_bus_sequencer_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  lcdnib_pkg::in_item_t                  in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output lcdnib_pkg::out_item_t                 out_data,
  input  logic                                  cfg_we,
  input  logic [lcdnib_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lcdnib_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  lcdnib_pkg::lcd_cfg_t      cfg_r, cfg_nxt;
  lcdnib_pkg::queue_status_t q_status;
  lcdnib_pkg::job_t          push_job;
  lcdnib_pkg::job_t          head_job;
  logic                      push;
  logic                      pop;

  // Timing registers: mask each write to its width, drop unknown indexes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (lcdnib_pkg::cfg_reg_t'(cfg_index))
        lcdnib_pkg::REG_ENABLE_PULSE: cfg_nxt.enable_pulse_us    = cfg_wdata[7:0];
        lcdnib_pkg::REG_NIBBLE_HOLD:  cfg_nxt.nibble_hold_us     = cfg_wdata[15:0];
        lcdnib_pkg::REG_CLEAR_WAIT:   cfg_nxt.clear_wait_us      = cfg_wdata[15:0];
        lcdnib_pkg::REG_POWER_WAIT:   cfg_nxt.power_on_wait_us   = cfg_wdata[19:0];
        lcdnib_pkg::REG_LONG_WAIT:    cfg_nxt.init_long_wait_us  = cfg_wdata[15:0];
        lcdnib_pkg::REG_SHORT_WAIT:   cfg_nxt.init_short_wait_us = cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_pulse_us    <= 8'd1;
      cfg_r.nibble_hold_us     <= 16'd50;
      cfg_r.clear_wait_us      <= 16'd2000;
      cfg_r.power_on_wait_us   <= 20'd50000;
      cfg_r.init_long_wait_us  <= 16'd5000;
      cfg_r.init_short_wait_us <= 16'd150;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Classify incoming beats.
  lcdnib_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  // Hold jobs until the back end takes them.
  lcdnib_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  // Expand each job into pin steps.
  lcdnib_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_status  (q_status),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("job popped from an empty queue");

  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!push && !pop) |=> $stable(q_status.count))
    else $error("queue count moved without push or pop");

  a_ready_tracks_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == !q_status.full)
    else $error("in_ready disagrees with queue fill");

endmodule
